/* design/tpcs_pkg.sv */
// shared constants, types and helpers for the tone prescaler compare select block
`default_nettype none
package tpcs_pkg;

    localparam int CLK_W        = 25;
    localparam int TONE_W       = 16;
    localparam int Q_W          = 24;
    localparam int CMP_W        = 16;
    localparam int SEL_W        = 3;
    localparam int NUM_PRESC    = 5;
    localparam int COUNTER_BITS = 16;
    localparam int PIPE_DEPTH   = 2 * Q_W + 1;

    localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(8000000);
    localparam logic [32:0]      TOP_LIMIT   = 33'(1) << COUNTER_BITS;

    localparam logic [SEL_W-1:0] LANE_P1    = 3'd0;
    localparam logic [SEL_W-1:0] LANE_P8    = 3'd1;
    localparam logic [SEL_W-1:0] LANE_P64   = 3'd2;
    localparam logic [SEL_W-1:0] LANE_P256  = 3'd3;
    localparam logic [SEL_W-1:0] LANE_P1024 = 3'd4;
    localparam logic [SEL_W-1:0] SEL_NONE   = 3'd0;

    typedef struct packed {
        logic [Q_W-1:0] num;
        logic [Q_W-1:0] rem;
        logic [Q_W-1:0] den;
    } div_t;

    typedef struct packed {
        logic             fit;
        logic [CMP_W-1:0] cmp;
        logic [Q_W-1:0]   act;
        logic [Q_W-1:0]   err;
    } cand_t;

    // clock / (2 * prescaler) as a plain shift
    function automatic logic [Q_W-1:0] numer(input logic [CLK_W-1:0] clk_hz,
                                             input logic [SEL_W-1:0] lane);
        logic [CLK_W-1:0] s;
        begin
            unique case (lane)
                LANE_P1:    s = clk_hz >> 1;
                LANE_P8:    s = clk_hz >> 4;
                LANE_P64:   s = clk_hz >> 7;
                LANE_P256:  s = clk_hz >> 9;
                LANE_P1024: s = clk_hz >> 11;
                default:    s = '0;
            endcase
            numer = s[Q_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* design/tone_prescaler_compare_select.sv */
// Tone prescaler compare select: picks timer prescaler and compare value for a tone.
//
// Input channel: in_valid / in_stall carry tone_hz, one word per request.
// Output channel: out_valid / out_stall carry compare_value, clock_select,
// actual_hz, error_hz and accepted, one word per request, in order.
// Config channel: cfg_valid / cfg_ready write clock_hz; cfg_ready is always high.
// The pipeline holds 24 restoring-division cells for the compare value,
// 24 more for the produced frequency, one register for the error and one for the
// pick among the five prescaler lanes, which all run side by side.
// Throughput is one request per cycle; the whole cell row advances together
// whenever the output register is free or being taken.
// When the receiver stalls with a word waiting, the row freezes and in_stall
// rises in the same cycle.
// Reset empties the pipeline and sets clock_hz to 8000000.
`default_nettype none
module tone_prescaler_compare_select (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [tpcs_pkg::TONE_W-1:0]    tone_hz,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [tpcs_pkg::CMP_W-1:0]          compare_value,
    output logic [tpcs_pkg::SEL_W-1:0]          clock_select,
    output logic [tpcs_pkg::Q_W-1:0]            actual_hz,
    output logic [tpcs_pkg::Q_W-1:0]            error_hz,
    output logic                                accepted,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tpcs_pkg::CLK_W-1:0]     clock_hz
);
    import tpcs_pkg::*;

    logic [CLK_W-1:0]  clock_hz_reg;
    logic              adv;
    logic              valid_reg [1:PIPE_DEPTH];
    logic [TONE_W-1:0] tone_reg  [1:PIPE_DEPTH-1];
    cand_t             cands [0:NUM_PRESC-1];
    logic              out_valid_reg;
    logic [CMP_W-1:0]  cmp_reg,  cmp_next;
    logic [SEL_W-1:0]  sel_reg,  sel_next;
    logic [Q_W-1:0]    act_reg,  act_next;
    logic [Q_W-1:0]    err_reg,  err_next;
    logic              acc_reg,  acc_next;

    assign cfg_ready = 1'b1;
    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            clock_hz_reg <= clock_hz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[1] <= in_valid;
            for (int i = 2; i <= PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
            out_valid_reg <= valid_reg[PIPE_DEPTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tone_reg[1] <= tone_hz;
            for (int i = 2; i <= PIPE_DEPTH - 1; i++)
            begin
                tone_reg[i] <= tone_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_PRESC; k++)
    begin : g_lanes
        tpcs_lane u_lane (
            .clk        (clk),
            .en         (adv),
            .lane       (SEL_W'(k)),
            .clk_hz     (clock_hz_reg),
            .tone_first (tone_hz),
            .tone_last  (tone_reg[PIPE_DEPTH-1]),
            .cand       (cands[k])
        );
    end

    // least error wins, ties stay with the smaller prescaler
    always_comb
    begin
        cmp_next = '0;
        sel_next = SEL_NONE;
        act_next = '0;
        err_next = '0;
        acc_next = 1'b0;
        for (int k = 0; k < NUM_PRESC; k++)
        begin
            if (cands[k].fit && (!acc_next || cands[k].err < err_next))
            begin
                acc_next = 1'b1;
                cmp_next = cands[k].cmp;
                sel_next = SEL_W'(k + 1);
                act_next = cands[k].act;
                err_next = cands[k].err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmp_reg <= cmp_next;
            sel_reg <= sel_next;
            act_reg <= act_next;
            err_reg <= err_next;
            acc_reg <= acc_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign compare_value = cmp_reg;
    assign clock_select  = sel_reg;
    assign actual_hz     = act_reg;
    assign error_hz      = err_reg;
    assign accepted      = acc_reg;

    a_sel_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> clock_select != SEL_NONE)
        else $error("accepted word without a prescaler");

    a_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> clock_select == SEL_NONE && compare_value == '0 &&
                                   actual_hz == '0 && error_hz == '0)
        else $error("rejected word with nonzero fields");

    a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && valid_reg[PIPE_DEPTH] |=> out_valid)
        else $error("finished word lost at output");

endmodule
`default_nettype wire

/* design/tpcs_div_cell.sv */
// one restoring division step, registered
`default_nettype none
module tpcs_div_cell (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire tpcs_pkg::div_t d,
    output tpcs_pkg::div_t    q
);
    import tpcs_pkg::*;

    logic [Q_W:0] trial;
    logic [Q_W:0] diff;
    logic         ge;
    div_t         q_reg;
    div_t         q_next;

    always_comb
    begin
        trial       = {d.rem, d.num[Q_W-1]};
        diff        = trial - {1'b0, d.den};
        ge          = trial >= {1'b0, d.den};
        q_next.rem  = ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
        q_next.num  = {d.num[Q_W-2:0], ge};
        q_next.den  = d.den;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

/* design/tpcs_lane.sv */
// one prescaler candidate: two chained dividers and the error of the result
`default_nettype none
module tpcs_lane (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [tpcs_pkg::SEL_W-1:0]     lane,
    input  wire logic [tpcs_pkg::CLK_W-1:0]     clk_hz,
    input  wire logic [tpcs_pkg::TONE_W-1:0]    tone_first,
    input  wire logic [tpcs_pkg::TONE_W-1:0]    tone_last,
    output tpcs_pkg::cand_t                     cand
);
    import tpcs_pkg::*;

    div_t           d1 [0:Q_W];
    div_t           d2 [0:Q_W];
    logic [Q_W-1:0] n_val;
    logic [Q_W-1:0] top;
    logic [Q_W-1:0] act;
    logic [Q_W-1:0] tone_w;
    cand_t          cand_reg;
    cand_t          cand_next;

    assign n_val = numer(clk_hz, lane);

    // top = n / tone, then actual = n / top
    assign d1[0] = '{num: n_val, rem: '0, den: {{(Q_W-TONE_W){1'b0}}, tone_first}};
    assign d2[0] = '{num: n_val, rem: '0, den: d1[Q_W].num};

    for (genvar i = 0; i < Q_W; i++)
    begin : g_cells
        tpcs_div_cell u_c1 (.clk(clk), .en(en), .d(d1[i]), .q(d1[i+1]));
        tpcs_div_cell u_c2 (.clk(clk), .en(en), .d(d2[i]), .q(d2[i+1]));
    end

    assign top    = d2[Q_W].den;
    assign act    = d2[Q_W].num;
    assign tone_w = {{(Q_W-TONE_W){1'b0}}, tone_last};

    always_comb
    begin
        cand_next.fit = (tone_last != '0) && (top != '0) &&
                        ({{(33-Q_W){1'b0}}, top} <= TOP_LIMIT);
        cand_next.cmp = CMP_W'(top - Q_W'(1));
        cand_next.act = act;
        cand_next.err = (act > tone_w) ? (act - tone_w) : (tone_w - act);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand = cand_reg;

endmodule
`default_nettype wire

/* test/tone_prescaler_compare_select_tb.sv */
// testbench for tone_prescaler_compare_select: directed table, then random tones over several clocks
`default_nettype none
module tone_prescaler_compare_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpcs_pkg::*;

    localparam logic [SEL_W-1:0] SEL_P64 = 3'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_PER_PHASE = 125;

    typedef struct packed {
        logic [CMP_W-1:0] cmp;
        logic [SEL_W-1:0] sel;
        logic [Q_W-1:0]   act;
        logic [Q_W-1:0]   err;
        logic             acc;
    } setting_t;

    typedef struct {
        logic [TONE_W-1:0] tone;
        bit                typed;
        setting_t          want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [TONE_W-1:0] tone_hz = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CMP_W-1:0] compare_value;
    logic [SEL_W-1:0] clock_select;
    logic [Q_W-1:0] actual_hz;
    logic [Q_W-1:0] error_hz;
    logic accepted;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CLK_W-1:0] clock_hz = CLOCK_RESET;

    logic [CLK_W-1:0] timer_clock = CLOCK_RESET;
    setting_t pending_settings[$];
    int mismatches = 0;

    tone_prescaler_compare_select i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .tone_hz(tone_hz),
        .out_valid(out_valid), .out_stall(out_stall),
        .compare_value(compare_value), .clock_select(clock_select),
        .actual_hz(actual_hz), .error_hz(error_hz), .accepted(accepted),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .clock_hz(clock_hz)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // best prescaler for a tone, ties kept by the smaller prescaler
    function automatic setting_t pick_prescaler(input logic [TONE_W-1:0] tone,
                                                input logic [CLK_W-1:0] fclk);
        longint unsigned divs[NUM_PRESC] = '{1, 8, 64, 256, 1024};
        longint unsigned top, act, err, best_err;
        setting_t s;
        bit found;
        s = '0;
        found = 0;
        best_err = 0;
        if (tone != 0)
        begin
            for (int k = 0; k < NUM_PRESC; k++)
            begin
                top = longint'(fclk) / (2 * divs[k] * longint'(tone));
                if (top == 0 || top - 1 > 64'hFFFF)
                    continue;
                act = longint'(fclk) / (2 * divs[k] * top);
                err = (act > tone) ? act - tone : tone - act;
                if (!found || err < best_err)
                begin
                    found = 1;
                    best_err = err;
                    s.cmp = CMP_W'(top - 1);
                    s.sel = SEL_W'(k + 1);
                    s.act = Q_W'(act);
                    s.err = Q_W'(err);
                    s.acc = 1'b1;
                end
            end
        end
        return s;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // one tone word; expectation is queued at the accepting edge
    task automatic send_tone(input logic [TONE_W-1:0] t, input bit typed,
                             input setting_t want);
        in_valid <= 1'b1;
        tone_hz <= t;
        do
            @(posedge clk);
        while (in_stall);
        pending_settings.push_back(typed ? want : pick_prescaler(t, timer_clock));
    endtask

    task automatic idle_gap();
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_clock(input logic [CLK_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_settings.size() != 0)
            @(posedge clk);
        clock_hz <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        timer_clock = v;
    endtask

    function automatic logic [TONE_W-1:0] random_tone();
        case ($urandom_range(0, 3))
            0, 1: return TONE_W'($urandom_range(1, 2000));
            2: return TONE_W'($urandom_range(0, 65535));
            default: return TONE_W'($urandom_range(2000, 65535));
        endcase
    endfunction

    // receiver: stall pattern switches between quiet, patchy and long holds
    int rx_cycle = 0;
    int rx_mode = 0;
    always @(posedge clk)
    begin
        setting_t w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_settings.size() == 0)
                    report("unexpected word", 0, 0);
                else
                begin
                    w = pending_settings.pop_front();
                    if (compare_value !== w.cmp) report("compare_value", compare_value, w.cmp);
                    if (clock_select !== w.sel) report("clock_select", clock_select, w.sel);
                    if (actual_hz !== w.act) report("actual_hz", actual_hz, w.act);
                    if (error_hz !== w.err) report("error_hz", error_hz, w.err);
                    if (accepted !== w.acc) report("accepted", accepted, w.acc);
                end
            end
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                default: out_stall <= ((rx_cycle / 8) % 2 == 1);
            endcase
        end
    end

    initial
    begin
        row_t rows[$];
        logic [CLK_W-1:0] clocks[$];
        rows = '{
            '{16'd0, 1'b1, setting_t'('0)},
            '{16'd1, 1'b1, '{cmp: 16'd62499, sel: SEL_P64, act: 24'd1, err: 24'd0, acc: 1'b1}},
            '{16'd65535, 1'b0, setting_t'('0)},
            '{16'd65534, 1'b0, setting_t'('0)},
            '{16'd32768, 1'b0, setting_t'('0)},
            '{16'h5555, 1'b0, setting_t'('0)},
            '{16'hAAAA, 1'b0, setting_t'('0)},
            '{16'd2, 1'b0, setting_t'('0)},
            '{16'd61, 1'b0, setting_t'('0)},
            '{16'd440, 1'b0, setting_t'('0)},
            '{16'd1000, 1'b0, setting_t'('0)},
            '{TONE_W'(4000000 % 65536), 1'b0, setting_t'('0)}
        };
        clocks = '{25'd1, 25'h1FFFFFF, 25'd16000000, 25'd1000000,
                   CLK_W'($urandom_range(1, 33554431)), CLK_W'($urandom_range(1, 200000)),
                   CLK_W'($urandom_range(1000000, 33554431))};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_tone(rows[i].tone, rows[i].typed, rows[i].want);
            idle_gap();
        end
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            send_tone(random_tone(), 1'b0, setting_t'('0));
            idle_gap();
        end

        foreach (clocks[p])
        begin
            write_clock(clocks[p]);
            // no fit is possible at a 1 Hz clock
            if (p == 0)
                send_tone(16'd1, 1'b1, setting_t'('0));
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                send_tone(random_tone(), 1'b0, setting_t'('0));
                idle_gap();
            end
        end
        in_valid <= 1'b0;

        while (pending_settings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
